FILE: design/message_header_tokenizer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the message header tokenizer
// Short forms for clocked concurrent assertions, with and without reset.
// ---------------------------------------------------------------------------
`ifndef MESSAGE_HEADER_TOKENIZER_TOP_MACROS_SVH
`define MESSAGE_HEADER_TOKENIZER_TOP_MACROS_SVH

// Checked only while reset is released.
`define MHT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MHT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mht_pkg.sv
// ---------------------------------------------------------------------------
// Message header tokenizer package
// Result kinds, result record, step summary and character constants.
// ---------------------------------------------------------------------------
package mht_pkg;

    typedef enum logic [2:0] {
        K_NAME      = 3'd0,
        K_NAME_END  = 3'd1,
        K_BODY      = 3'd2,
        K_FIELD_END = 3'd3,
        K_DONE      = 3'd4,
        K_INVALID   = 3'd5,
        K_TOO_LARGE = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tbyte;
        logic        last;
    } t_token;

    typedef struct packed {
        logic [1:0]  count;
        t_token      tok0;
        t_token      tok1;
    } t_step;

    localparam int unsigned LIMIT_W = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8192;

    localparam logic [7:0] C_COLON    = 8'h3A;
    localparam logic [7:0] C_CR       = 8'h0D;
    localparam logic [7:0] C_LF       = 8'h0A;
    localparam logic [7:0] C_PRINT_LO = 8'd33;
    localparam logic [7:0] C_PRINT_HI = 8'd126;
    localparam logic [7:0] C_WS_LO    = 8'd9;
    localparam logic [7:0] C_WS_HI    = 8'd13;
    localparam logic [7:0] C_SPACE    = 8'd32;

    function automatic t_token make_token(input t_kind kind, input logic [7:0] tbyte);
        t_token t;
        t.kind  = kind;
        t.tbyte = tbyte;
        t.last  = 1'b0;
        return t;
    endfunction

endpackage

FILE: design/mht_if.sv
// ---------------------------------------------------------------------------
// Message header tokenizer channels
// Input byte channel and result channel, each with valid and ready.
// ---------------------------------------------------------------------------
interface mht_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface mht_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [7:0]  token_byte;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_byte,
                    input last_of_run, output ready);
endinterface

FILE: design/mht_core.sv
// ---------------------------------------------------------------------------
// Message header tokenizer parse core
// Holds the parse phase and stored byte count, and works out the results
// of one byte from them.
// ---------------------------------------------------------------------------
module mht_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic                        i_action,
    input  logic [7:0]                  i_data_byte,
    input  logic [mht_pkg::LIMIT_W-1:0] i_limit,
    output mht_pkg::t_step              o_step
);

    typedef enum logic [3:0] {
        PH_LINE0   = 4'd0,
        PH_CR      = 4'd1,
        PH_NAME    = 4'd2,
        PH_NAMESP  = 4'd3,
        PH_BODY0   = 4'd4,
        PH_BODY    = 4'd5,
        PH_BODY_CR = 4'd6,
        PH_NEWLINE = 4'd7,
        PH_END_CR  = 4'd8,
        PH_HALT    = 4'd9
    } t_phase;

    t_phase                      r_phase;
    t_phase                      n_phase;
    logic [mht_pkg::LIMIT_W-1:0] r_count;
    logic [mht_pkg::LIMIT_W-1:0] n_count;
    mht_pkg::t_step              step;

    always_comb begin
        logic [mht_pkg::LIMIT_W:0] sum1;
        logic [mht_pkg::LIMIT_W:0] sum2;
        logic                      ok1;
        logic                      ok2;
        logic                      is_ws;
        logic                      is_print;
        logic                      is_colon;
        logic [7:0]                c;

        c        = i_data_byte;
        sum1     = {1'b0, r_count} + {{mht_pkg::LIMIT_W{1'b0}}, 1'b1};
        sum2     = {1'b0, r_count} + {{(mht_pkg::LIMIT_W-1){1'b0}}, 2'd2};
        ok1      = sum1 < {1'b0, i_limit};
        ok2      = sum2 < {1'b0, i_limit};
        is_ws    = (c == mht_pkg::C_SPACE) || (c inside {[mht_pkg::C_WS_LO:mht_pkg::C_WS_HI]});
        is_print = c inside {[mht_pkg::C_PRINT_LO:mht_pkg::C_PRINT_HI]};
        is_colon = c == mht_pkg::C_COLON;

        n_phase    = r_phase;
        n_count    = r_count;
        step.count = 2'd0;
        step.tok0  = mht_pkg::make_token(mht_pkg::K_NAME, 8'd0);
        step.tok1  = mht_pkg::make_token(mht_pkg::K_NAME, 8'd0);

        if (i_action) begin
            n_phase = PH_LINE0;
            n_count = '0;
        end else begin
            case (r_phase)
                PH_LINE0: begin
                    if (is_print && !is_colon) begin
                        step.count = 2'd1;
                        if (ok1) begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_NAME, c);
                            n_count   = sum1[mht_pkg::LIMIT_W-1:0];
                            n_phase   = PH_NAME;
                        end else begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase   = PH_HALT;
                        end
                    end else if (c == mht_pkg::C_LF) begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_DONE, 8'd0);
                        n_phase    = PH_HALT;
                    end else if (c == mht_pkg::C_CR) begin
                        n_phase = PH_CR;
                    end else if (!is_ws) begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                        n_phase    = PH_HALT;
                    end
                end
                PH_CR: begin
                    step.count = 2'd1;
                    step.tok0  = mht_pkg::make_token((c == mht_pkg::C_LF) ?
                                 mht_pkg::K_DONE : mht_pkg::K_INVALID, 8'd0);
                    n_phase    = PH_HALT;
                end
                PH_NAME: begin
                    step.count = 2'd1;
                    if (is_colon || (is_ws && !is_print)) begin
                        if (ok2) begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_NAME_END, 8'd0);
                            n_count   = sum2[mht_pkg::LIMIT_W-1:0];
                            n_phase   = is_colon ? PH_BODY0 : PH_NAMESP;
                        end else begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase   = PH_HALT;
                        end
                    end else if (is_print) begin
                        if (ok1) begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_NAME, c);
                            n_count   = sum1[mht_pkg::LIMIT_W-1:0];
                        end else begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase   = PH_HALT;
                        end
                    end else begin
                        step.tok0 = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                        n_phase   = PH_HALT;
                    end
                end
                PH_NAMESP: begin
                    if (is_colon) begin
                        n_phase = PH_BODY0;
                    end else if (!is_ws) begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                        n_phase    = PH_HALT;
                    end
                end
                PH_BODY0, PH_BODY: begin
                    if (c == mht_pkg::C_CR || c == mht_pkg::C_LF) begin
                        if (ok1) begin
                            n_count = sum1[mht_pkg::LIMIT_W-1:0];
                            n_phase = (c == mht_pkg::C_CR) ? PH_BODY_CR : PH_NEWLINE;
                        end else begin
                            step.count = 2'd1;
                            step.tok0  = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase    = PH_HALT;
                        end
                    end else if (r_phase == PH_BODY || !is_ws) begin
                        step.count = 2'd1;
                        if (ok1) begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_BODY, c);
                            n_count   = sum1[mht_pkg::LIMIT_W-1:0];
                            n_phase   = PH_BODY;
                        end else begin
                            step.tok0 = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase   = PH_HALT;
                        end
                    end
                end
                PH_BODY_CR: begin
                    if (c == mht_pkg::C_LF) begin
                        n_phase = PH_NEWLINE;
                    end else begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                        n_phase    = PH_HALT;
                    end
                end
                PH_NEWLINE: begin
                    if (c == mht_pkg::C_CR) begin
                        n_phase = PH_END_CR;
                    end else if (c == mht_pkg::C_LF) begin
                        step.count = 2'd2;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_FIELD_END, 8'd0);
                        step.tok1  = mht_pkg::make_token(mht_pkg::K_DONE, 8'd0);
                        n_phase    = PH_HALT;
                    end else if (is_ws) begin
                        if (ok1) begin
                            step.count = 2'd2;
                            step.tok0  = mht_pkg::make_token(mht_pkg::K_BODY, mht_pkg::C_LF);
                            step.tok1  = mht_pkg::make_token(mht_pkg::K_BODY, c);
                            n_count    = sum1[mht_pkg::LIMIT_W-1:0];
                            n_phase    = PH_BODY;
                        end else begin
                            step.count = 2'd1;
                            step.tok0  = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase    = PH_HALT;
                        end
                    end else if (is_print && !is_colon) begin
                        step.count = 2'd2;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_FIELD_END, 8'd0);
                        if (ok1) begin
                            step.tok1 = mht_pkg::make_token(mht_pkg::K_NAME, c);
                            n_count   = sum1[mht_pkg::LIMIT_W-1:0];
                            n_phase   = PH_NAME;
                        end else begin
                            step.tok1 = mht_pkg::make_token(mht_pkg::K_TOO_LARGE, 8'd0);
                            n_phase   = PH_HALT;
                        end
                    end else begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                        n_phase    = PH_HALT;
                    end
                end
                PH_END_CR: begin
                    if (c == mht_pkg::C_LF) begin
                        step.count = 2'd2;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_FIELD_END, 8'd0);
                        step.tok1  = mht_pkg::make_token(mht_pkg::K_DONE, 8'd0);
                    end else begin
                        step.count = 2'd1;
                        step.tok0  = mht_pkg::make_token(mht_pkg::K_INVALID, 8'd0);
                    end
                    n_phase = PH_HALT;
                end
                PH_HALT: begin
                    n_phase = PH_HALT;
                end
                default: begin
                    n_phase = PH_HALT;
                end
            endcase
        end

        step.tok0.last = step.count == 2'd1;
        step.tok1.last = step.count == 2'd2;
    end

    assign o_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE0;
            r_count <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

FILE: design/message_header_tokenizer_top.sv
// ---------------------------------------------------------------------------
// Message header tokenizer
// Splits a byte stream of name:body header lines into tagged tokens.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_in      sink       action, data_byte
//  o_out     source     token_kind, token_byte, last_of_run
//  i_cfg_*   write      header_limit, 16 bits
//
//  A byte is parsed in the cycle of its transfer and its results are held in
//  a two-entry result queue, from which they leave through the output channel
//  one at a time.
//  The input is ready when the queue will be empty after this cycle.
//  Reset is synchronous and restores the line start phase, a zero byte count,
//  an empty queue and a limit of 8192.
// ---------------------------------------------------------------------------
module message_header_tokenizer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mht_in_if.sink                      i_in,
    mht_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [mht_pkg::LIMIT_W-1:0] i_cfg_wdata
);

    logic [mht_pkg::LIMIT_W-1:0] r_limit;
    mht_pkg::t_token             r_q [2];
    logic [1:0]                  r_cnt;
    mht_pkg::t_step              step;
    logic                        take;
    logic                        pop;

    assign pop      = (r_cnt != 2'd0) && o_out.ready;
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign take     = i_in.valid && i_in.ready;

    mht_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_action    (i_in.action),
        .i_data_byte (i_in.data_byte),
        .i_limit     (r_limit),
        .o_step      (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= mht_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (take) begin
            r_cnt   <= step.count;
            r_q[0]  <= step.tok0;
            r_q[1]  <= step.tok1;
        end else if (pop) begin
            r_cnt   <= r_cnt - 2'd1;
            r_q[0]  <= r_q[1];
        end
    end

    assign o_out.valid       = r_cnt != 2'd0;
    assign o_out.token_kind  = r_q[0].kind;
    assign o_out.token_byte  = r_q[0].tbyte;
    assign o_out.last_of_run = r_q[0].last;

endmodule

FILE: design/mht_checker.sv
// ---------------------------------------------------------------------------
// Message header tokenizer checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "message_header_tokenizer_top_macros.svh"

module mht_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_token_kind,
    input  logic [7:0]  i_token_byte,
    input  logic        i_last_of_run
);

    `MHT_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `MHT_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_token_kind, i_token_byte, i_last_of_run}), "stalled transfer changed")
    `MHT_ASSERT(a_kind_range, i_clk, i_rst_n, i_out_valid |-> i_token_kind != 3'd7, "unknown result kind")
    `MHT_ASSERT(a_byte_zero, i_clk, i_rst_n, i_out_valid && i_token_kind != mht_pkg::K_NAME && i_token_kind != mht_pkg::K_BODY |-> i_token_byte == 8'd0, "byte set on a marker result")
    `MHT_ASSERT(a_stop_last, i_clk, i_rst_n, i_out_valid && (i_token_kind == mht_pkg::K_DONE || i_token_kind == mht_pkg::K_INVALID || i_token_kind == mht_pkg::K_TOO_LARGE) |-> i_last_of_run, "stop result not last of its byte")

endmodule

bind message_header_tokenizer_top mht_checker u_mht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_token_kind  (o_out.token_kind),
    .i_token_byte  (o_out.token_byte),
    .i_last_of_run (o_out.last_of_run)
);

FILE: tb/message_header_tokenizer_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Message header tokenizer regression
// A directed table and random headers are fed through the byte channel while
// both channels idle at random; every token is checked against the table or a predictor.
// ---------------------------------------------------------------------------
module message_header_tokenizer_top_tb;
    import mht_pkg::*;

    typedef enum logic [3:0] {
        P_LINE_START, P_CR_SEEN, P_IN_NAME, P_NAME_SPACE, P_BODY_START,
        P_IN_BODY, P_BODY_CR, P_LINE_END, P_BLANK_CR, P_HALTED
    } t_phase;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } t_stall;

    typedef struct packed {
        bit          set_limit;
        logic        act;
        logic [15:0] value;
        bit          typed;
        logic [1:0]  n_exp;
        t_kind       k0;
        logic [7:0]  b0;
        t_kind       k1;
        logic [7:0]  b1;
    } t_row;

    localparam int N_DIRECTED  = 34;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE      = 4;
    localparam int DRAIN_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LIMIT_W-1:0] i_cfg_wdata;

    mht_in_if  hdr_in ();
    mht_out_if tok_out ();

    message_header_tokenizer_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (hdr_in),
        .o_out       (tok_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_phase       phase_m = P_LINE_START;
    logic [15:0]  count_m = '0;
    logic [15:0]  limit_m = LIMIT_RESET;
    t_token       step_tokens [$];
    t_token       pending_tokens [$];
    t_row         rows_in_flight [$];

    int fail_count = 0;
    int items_sent = 0;
    int tokens_checked = 0;
    int headers_sent = 0;
    int limit_writes = 0;
    int burst_left = 0;
    int kind_seen [8];

    t_row directed_rows [N_DIRECTED] = '{
        '{0, 0, "A",     1, 1, K_NAME,      "A",   K_NAME,  0},
        '{0, 0, "~",     0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_SPACE, 1, 1, K_NAME_END,  0,     K_NAME,  0},
        '{0, 0, C_COLON, 1, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_SPACE, 1, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, 8'hFF,   1, 1, K_BODY,      8'hFF, K_NAME,  0},
        '{0, 0, C_CR,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_LF,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, 8'h09,   1, 2, K_BODY,      C_LF,  K_BODY,  8'h09},
        '{0, 0, C_LF,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "!",     1, 2, K_FIELD_END, 0,     K_NAME,  "!"},
        '{0, 0, C_COLON, 0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, 8'h00,   1, 1, K_BODY,      8'h00, K_NAME,  0},
        '{0, 0, C_CR,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_LF,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_CR,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_LF,    1, 2, K_FIELD_END, 0,     K_DONE,  0},
        '{0, 0, "z",     1, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 1, 8'h00,   1, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_COLON, 1, 1, K_INVALID,   0,     K_NAME,  0},
        '{0, 1, 8'hFF,   0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_CR,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "q",     1, 1, K_INVALID,   0,     K_NAME,  0},
        '{0, 1, 8'h00,   0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "N",     0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_COLON, 0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_LF,    0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, C_COLON, 1, 1, K_INVALID,   0,     K_NAME,  0},
        '{1, 0, 16'd3,   0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 1, 8'h00,   0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "a",     0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "b",     0, 0, K_NAME,      0,     K_NAME,  0},
        '{0, 0, "c",     1, 1, K_TOO_LARGE, 0,     K_NAME,  0},
        '{0, 0, "d",     1, 0, K_NAME,      0,     K_NAME,  0}
    };

    // Predictor of the tokenizer.

    function automatic bit is_space(logic [7:0] c);
        return c == C_SPACE || (c >= C_WS_LO && c <= C_WS_HI);
    endfunction

    function automatic bit is_graph(logic [7:0] c);
        return c >= C_PRINT_LO && c <= C_PRINT_HI;
    endfunction

    function automatic void emit_tok(t_kind k, logic [7:0] b);
        t_token t;
        t.kind  = k;
        t.tbyte = b;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void bad_char();
        emit_tok(K_INVALID, 8'h00);
        phase_m = P_HALTED;
    endfunction

    function automatic void end_header();
        emit_tok(K_DONE, 8'h00);
        phase_m = P_HALTED;
    endfunction

    // The header store holds a running byte count; a store that would reach the
    // limit fails the whole header.
    function automatic bit reserve(int unsigned n);
        if (17'(count_m) + 17'(n) >= 17'(limit_m)) begin
            emit_tok(K_TOO_LARGE, 8'h00);
            phase_m = P_HALTED;
            return 1'b0;
        end
        count_m = count_m + 16'(n);
        return 1'b1;
    endfunction

    function automatic void tokenize_byte(logic [7:0] c);
        case (phase_m)
            P_LINE_START: begin
                if (is_graph(c) && c != C_COLON) begin
                    if (reserve(1)) begin
                        emit_tok(K_NAME, c);
                        phase_m = P_IN_NAME;
                    end
                end else if (c == C_LF) begin
                    end_header();
                end else if (c == C_CR) begin
                    phase_m = P_CR_SEEN;
                end else if (!is_space(c)) begin
                    bad_char();
                end
            end
            P_CR_SEEN: begin
                if (c == C_LF) end_header();
                else bad_char();
            end
            P_IN_NAME: begin
                if (c == C_COLON) begin
                    if (reserve(2)) begin
                        emit_tok(K_NAME_END, 8'h00);
                        phase_m = P_BODY_START;
                    end
                end else if (is_graph(c)) begin
                    if (reserve(1)) emit_tok(K_NAME, c);
                end else if (is_space(c)) begin
                    if (reserve(2)) begin
                        emit_tok(K_NAME_END, 8'h00);
                        phase_m = P_NAME_SPACE;
                    end
                end else begin
                    bad_char();
                end
            end
            P_NAME_SPACE: begin
                if (c == C_COLON) phase_m = P_BODY_START;
                else if (!is_space(c)) bad_char();
            end
            P_BODY_START, P_IN_BODY: begin
                if (c == C_CR || c == C_LF) begin
                    if (reserve(1)) phase_m = (c == C_CR) ? P_BODY_CR : P_LINE_END;
                end else if (phase_m == P_IN_BODY || !is_space(c)) begin
                    if (reserve(1)) begin
                        emit_tok(K_BODY, c);
                        phase_m = P_IN_BODY;
                    end
                end
            end
            P_BODY_CR: begin
                if (c == C_LF) phase_m = P_LINE_END;
                else bad_char();
            end
            P_LINE_END: begin
                if (c == C_CR) begin
                    phase_m = P_BLANK_CR;
                end else if (c == C_LF) begin
                    emit_tok(K_FIELD_END, 8'h00);
                    end_header();
                end else if (is_space(c)) begin
                    if (reserve(1)) begin
                        emit_tok(K_BODY, C_LF);
                        emit_tok(K_BODY, c);
                        phase_m = P_IN_BODY;
                    end
                end else if (is_graph(c) && c != C_COLON) begin
                    emit_tok(K_FIELD_END, 8'h00);
                    if (reserve(1)) begin
                        emit_tok(K_NAME, c);
                        phase_m = P_IN_NAME;
                    end
                end else begin
                    bad_char();
                end
            end
            P_BLANK_CR: begin
                if (c == C_LF) begin
                    emit_tok(K_FIELD_END, 8'h00);
                    end_header();
                end else begin
                    bad_char();
                end
            end
            default: phase_m = P_HALTED;
        endcase
    endfunction

    function automatic void tokenize_item(logic act, logic [7:0] c);
        t_token t;
        step_tokens.delete();
        if (act) begin
            phase_m = P_LINE_START;
            count_m = '0;
        end else begin
            tokenize_byte(c);
        end
        if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
    endfunction

    function automatic void note_fail(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Clock and receiver stalls.

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        t_stall stall_mode;
        int     stall_cycle;
        stall_mode = STALL_NONE;
        stall_cycle = 0;
        tok_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            stall_cycle++;
            if (stall_cycle % 80 == 0) stall_mode = stall_mode.next();
            case (stall_mode)
                STALL_NONE:     tok_out.ready <= 1'b1;
                STALL_LIGHT:    tok_out.ready <= ($urandom_range(0, 3) != 0);
                STALL_HEAVY:    tok_out.ready <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: tok_out.ready <= (stall_cycle % 5 < 2);
                default:        tok_out.ready <= 1'b1;
            endcase
        end
    end

    // Transfers on both channels are taken in one place so that expectations
    // are always queued before the tokens they describe are compared.
    always @(posedge i_clk) begin
        t_row   r;
        t_token t;
        if (i_rst_n) begin
            if (hdr_in.valid && hdr_in.ready) begin
                r = rows_in_flight.pop_front();
                tokenize_item(hdr_in.action, hdr_in.data_byte);
                if (r.typed) begin
                    for (int i = 0; i < int'(r.n_exp); i++) begin
                        t.kind  = (i == 0) ? r.k0 : r.k1;
                        t.tbyte = (i == 0) ? r.b0 : r.b1;
                        t.last  = (i == int'(r.n_exp) - 1);
                        pending_tokens.push_back(t);
                    end
                end else begin
                    foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
                end
            end
            if (tok_out.valid && tok_out.ready) begin
                tokens_checked++;
                kind_seen[tok_out.token_kind]++;
                if (pending_tokens.size() == 0) begin
                    note_fail($sformatf("unexpected token kind %0d byte 0x%02h last %0b",
                        tok_out.token_kind, tok_out.token_byte, tok_out.last_of_run));
                end else begin
                    t = pending_tokens.pop_front();
                    if (tok_out.token_kind !== t.kind || tok_out.token_byte !== t.tbyte ||
                            tok_out.last_of_run !== t.last) begin
                        note_fail($sformatf(
                            "token mismatch: expected %s 0x%02h last %0b, got %0d 0x%02h last %0b",
                            t.kind.name(), t.tbyte, t.last, tok_out.token_kind,
                            tok_out.token_byte, tok_out.last_of_run));
                    end
                end
            end
        end
    end

    // Stimulus.

    function automatic t_row byte_row(logic act, logic [7:0] c);
        t_row r;
        r = '0;
        r.act = act;
        r.value = {8'h00, c};
        return r;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            default: return C_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] pick_name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(C_PRINT_LO, C_PRINT_HI)); while (c == C_COLON);
        return c;
    endfunction

    function automatic logic [7:0] pick_body_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == C_CR || c == C_LF);
        return c;
    endfunction

    task automatic drive_item(t_row r);
        int gap;
        rows_in_flight.push_back(r);
        hdr_in.valid     <= 1'b1;
        hdr_in.action    <= r.act;
        hdr_in.data_byte <= r.value[7:0];
        do @(posedge i_clk); while (hdr_in.ready !== 1'b1);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                hdr_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_idle();
        hdr_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        limit_m = v;
        limit_writes++;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed headers with random content; some are damaged,
    // cut short, or plain noise.
    task automatic send_random_header();
        logic [7:0] hb [$];
        int         n_fields;
        int         pick;
        hb.delete();
        n_fields = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            repeat ($urandom_range(1, 6)) hb.push_back(pick_name_char());
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) hb.push_back(pick_blank());
            hb.push_back(C_COLON);
            if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 2)) hb.push_back(pick_blank());
            repeat ($urandom_range(0, 10)) hb.push_back(pick_body_char());
            for (int k = $urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0; k >= 0; k--) begin
                if ($urandom_range(0, 1) == 0) hb.push_back(C_CR);
                hb.push_back(C_LF);
                if (k > 0) begin
                    hb.push_back(pick_blank());
                    repeat ($urandom_range(0, 6)) hb.push_back(pick_body_char());
                end
            end
        end
        if ($urandom_range(0, 1) == 0) hb.push_back(C_CR);
        hb.push_back(C_LF);

        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            hb.delete();
            repeat ($urandom_range(4, 20)) hb.push_back(8'($urandom_range(0, 255)));
        end else if (pick <= 2) begin
            hb[$urandom_range(0, hb.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick == 3) begin
            hb = hb[0:$urandom_range(0, hb.size() - 1)];
        end

        headers_sent++;
        drive_item(byte_row(1'b1, 8'($urandom_range(0, 255))));
        foreach (hb[i]) drive_item(byte_row(1'b0, hb[i]));
    endtask

    initial begin
        logic [15:0] phase_limits [N_PHASES];
        int          target;
        int          drain;
        phase_limits = '{16'd16, 16'd65535, 16'd48, 16'd0, LIMIT_RESET};
        phase_limits[3] = 16'($urandom_range(17, 300));

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        hdr_in.valid     = 1'b0;
        hdr_in.action    = 1'b0;
        hdr_in.data_byte = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_limit) write_limit(directed_rows[i].value);
            else drive_item(directed_rows[i]);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_limit(phase_limits[p]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) send_random_header();
        end

        hdr_in.valid <= 1'b0;
        @(posedge i_clk);
        drain = 0;
        while (pending_tokens.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            note_fail($sformatf("%0d expected tokens never arrived", pending_tokens.size()));
        end

        $display("Checked %0d tokens from %0d byte transfers, %0d random headers, %0d limits.",
            tokens_checked, items_sent, headers_sent, limit_writes);
        $display("Headers ended as done %0d, invalid char %0d, too large %0d; %0d failures.",
            kind_seen[K_DONE], kind_seen[K_INVALID], kind_seen[K_TOO_LARGE], fail_count);
        if (fail_count == 0) begin
            $display("message_header_tokenizer_top regression: pass");
        end else begin
            $display("message_header_tokenizer_top regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d tokens still expected.", pending_tokens.size());
        $display("message_header_tokenizer_top regression: fail");
        $finish;
    end

endmodule
